/* rtl/core/gsd_pkg.sv */
// Package for the grouped standard deviation block.
// Holds the word types, status codes, sizes and state encoding; depends on nothing.
package gsd_pkg;

	localparam int MAX_CLASSES = 256;
	localparam int ADDR_W      = $clog2(MAX_CLASSES);
	localparam int CNT_W       = $clog2(MAX_CLASSES + 1);

	localparam int MUL_STEPS  = 42;
	localparam int SQRT_STEPS = 48;
	localparam int DIV_STEPS  = 48;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_FEW_ROWS = 3'd1,
		ST_ZERO_INT = 3'd2,
		ST_ZERO_FRQ = 3'd3,
		ST_OVERFLOW = 3'd4
	} status_t;

	typedef struct packed {
		logic [15:0] class_low;
		logic [15:0] class_high;
		logic [15:0] frequency;
		logic        last_row;
	} in_word_t;

	typedef struct packed {
		logic [23:0] std_dev;
		logic [2:0]  status;
	} out_word_t;

	typedef enum logic [9:0] {
		S_IDLE = 10'b0000000001,
		S_CEN  = 10'b0000000010,
		S_CLD  = 10'b0000000100,
		S_RD   = 10'b0000001000,
		S_M1   = 10'b0000010000,
		S_M2   = 10'b0000100000,
		S_AC   = 10'b0001000000,
		S_MULF = 10'b0010000000,
		S_MULS = 10'b0100000000,
		S_SQRT = 10'b1000000000
	} state_t;

endpackage

/* rtl/core/grouped_standard_deviation.sv */
// Top level of the grouped standard deviation block: row buffer, sequencer and
// the shared shift-add, square root and divide steps. Depends on gsd_pkg.
//
// Usage. Class rows are offered as one word on row with start high; a word is
// taken at a rising edge where start is high and busy is low. Rows that are not
// marked last are stored and busy stays low, so a table loads at one row per
// cycle. The row marked last closes the table. If the table is in error
// (overflow, fewer than two rows, zero interval or zero total frequency) the
// result word appears on result with done high in the very next cycle and busy
// never rises. Otherwise busy rises and the block walks the buffer row by row
// through S_RD, S_M1, S_M2 and S_AC to form the frequency sums, then runs a
// bit-serial multiplier for two 42-step products, a 48-step square root and a
// 48-step restoring divide. The result is shown for exactly one cycle with done
// high; the receiver cannot stall it and must take it then. Reset clears the row
// count, the running total, the interval and the overflow flag and returns the
// sequencer to idle; the buffer contents are not cleared, as only rows of the
// current table are read.
module grouped_standard_deviation (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  gsd_pkg::in_word_t  row,
	output logic               busy,
	output gsd_pkg::out_word_t result,
	output logic               done
);
	import gsd_pkg::*;

	// Row buffer: doubled midpoints and frequencies.
	logic [16:0] mid_mem [0:MAX_CLASSES-1];
	logic [15:0] frq_mem [0:MAX_CLASSES-1];
	logic [16:0] rd_m_q;
	logic [15:0] rd_f_q;
	logic [ADDR_W-1:0] rd_addr;

	// Table bookkeeping while rows load.
	logic [CNT_W-1:0] row_cnt_q;
	logic             ovf_q;
	logic [16:0]      width_q;
	logic [23:0]      tot_q;

	logic             accept;
	logic             room;
	logic [CNT_W-1:0] row_cnt_n;
	logic             ovf_n;
	logic [16:0]      width_n;
	logic [24:0]      tot_sum;
	logic [23:0]      tot_n;
	status_t          status_n;

	// Sequencer and datapath registers.
	state_t           state_q;
	logic [CNT_W-1:0] n_q;
	logic [CNT_W-1:0] idx_q;
	logic [23:0]      ftot_q;
	logic [16:0]      a2_q;
	logic             neg_q;
	logic [16:0]      dm_q;
	logic [32:0]      p1_q;
	logic [49:0]      p2_q;
	logic signed [42:0] s1_q;
	logic [57:0]      s2_q;
	logic [83:0]      ma_q;
	logic [41:0]      mb_q;
	logic [83:0]      acc_q;
	logic [83:0]      prod_q;
	logic [5:0]       step_q;
	logic [95:0]      x_q;
	logic [49:0]      sq_rem_q;
	logic [47:0]      root_q;
	logic [23:0]      dv_rem_q;
	logic             div_q;
	out_word_t        result_q;
	logic             done_q;

	// Combinational helpers.
	logic signed [17:0] d_w;
	logic [16:0]        dm_w;
	logic [32:0]        p1_w;
	logic [49:0]        p2_w;
	logic [41:0]        s1mag;
	logic [83:0]        q_w;
	logic [51:0]        sq_sh;
	logic [51:0]        sq_trial;
	logic               sq_ge;
	logic [24:0]        dv_sh;
	logic               dv_ge;
	logic [CNT_W-1:0]   cen_idx;

	assign accept = start && !busy;
	assign busy   = (state_q != S_IDLE) || div_q;
	assign result = result_q;
	assign done   = done_q;

	// Next table values as if the offered row were taken.
	always_comb begin
		room      = row_cnt_q < CNT_W'(MAX_CLASSES);
		row_cnt_n = room ? row_cnt_q + CNT_W'(1) : row_cnt_q;
		width_n   = width_q;
		if (room && row_cnt_q == CNT_W'(1)) begin
			width_n = {1'b0, row.class_high} - {1'b0, row.class_low};
		end
		tot_sum = {1'b0, tot_q} + {9'd0, row.frequency};
		tot_n   = tot_sum[24] ? 24'hFFFFFF : tot_sum[23:0];
		ovf_n   = ovf_q || !room || tot_sum[24];
		if (ovf_n) begin
			status_n = ST_OVERFLOW;
		end else if (row_cnt_n < CNT_W'(2)) begin
			status_n = ST_FEW_ROWS;
		end else if (width_n == 17'd0) begin
			status_n = ST_ZERO_INT;
		end else if (tot_n == 24'd0) begin
			status_n = ST_ZERO_FRQ;
		end else begin
			status_n = ST_OK;
		end
	end

	// The assumed mean comes from row n/2 counting from one.
	assign cen_idx = (n_q >> 1) - CNT_W'(1);
	assign rd_addr = (state_q == S_CEN) ? cen_idx[ADDR_W-1:0] : idx_q[ADDR_W-1:0];

	always_ff @(posedge clk) begin
		if (accept && room) begin
			mid_mem[row_cnt_q[ADDR_W-1:0]] <= {1'b0, row.class_low} + {1'b0, row.class_high};
			frq_mem[row_cnt_q[ADDR_W-1:0]] <= row.frequency;
		end
		rd_m_q <= mid_mem[rd_addr];
		rd_f_q <= frq_mem[rd_addr];
	end

	// Per-row arithmetic of the walk.
	always_comb begin
		d_w   = $signed({1'b0, rd_m_q}) - $signed({1'b0, a2_q});
		dm_w  = d_w[17] ? 17'(-d_w) : d_w[16:0];
		p1_w  = 33'(rd_f_q * dm_w);
		p2_w  = 50'(p1_q * dm_q);
		s1mag = s1_q[42] ? 42'(-s1_q) : s1_q[41:0];
		q_w   = prod_q - acc_q;
	end

	// One step of the digit-by-digit square root and of the restoring divide.
	always_comb begin
		sq_sh    = {sq_rem_q, x_q[95:94]};
		sq_trial = {2'b00, root_q, 2'b01};
		sq_ge    = sq_sh >= sq_trial;
		dv_sh    = {dv_rem_q, root_q[47]};
		dv_ge    = dv_sh >= {1'b0, ftot_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			row_cnt_q <= '0;
			ovf_q     <= 1'b0;
			width_q   <= '0;
			tot_q     <= '0;
			div_q     <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			// The word is shown at once for a table in error, else when the divide ends.
			done_q <= (accept && row.last_row && status_n != ST_OK)
				|| (state_q == S_IDLE && div_q && step_q == 6'd0);
			if (accept) begin
				if (row.last_row) begin
					row_cnt_q <= '0;
					ovf_q     <= 1'b0;
					width_q   <= '0;
					tot_q     <= '0;
					if (status_n == ST_OK) begin
						state_q <= S_CEN;
					end
				end else begin
					row_cnt_q <= row_cnt_n;
					ovf_q     <= ovf_n;
					width_q   <= width_n;
					tot_q     <= tot_n;
				end
			end
			case (state_q)
				S_IDLE: begin
					if (div_q && step_q == 6'd0) begin
						div_q <= 1'b0;
					end
				end
				S_CEN:  state_q <= S_CLD;
				S_CLD:  state_q <= S_M1;
				S_RD:   state_q <= S_M1;
				S_M1:   state_q <= S_M2;
				S_M2:   state_q <= S_AC;
				S_AC: begin
					if (idx_q == n_q) begin
						state_q <= S_MULF;
					end else begin
						state_q <= S_RD;
					end
				end
				S_MULF: begin
					if (step_q == 6'd0) begin
						state_q <= S_MULS;
					end
				end
				S_MULS: begin
					if (step_q == 6'd0) begin
						state_q <= S_SQRT;
					end
				end
				S_SQRT: begin
					if (step_q == 6'd0) begin
						state_q <= S_IDLE;
						div_q   <= 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers; no reset needed.
	always_ff @(posedge clk) begin
		if (accept && row.last_row) begin
			n_q      <= row_cnt_n;
			ftot_q   <= tot_n;
			result_q <= '{std_dev: 24'd0, status: status_n};
		end
		case (state_q)
			S_IDLE: begin
				if (div_q) begin
					dv_rem_q <= dv_ge ? 24'(dv_sh - {1'b0, ftot_q}) : dv_sh[23:0];
					root_q   <= {root_q[46:0], dv_ge};
					step_q   <= step_q - 6'd1;
					if (step_q == 6'd0) begin
						result_q.status  <= ST_OK;
						result_q.std_dev <= (root_q[46:23] != 24'd0) ? 24'hFFFFFF
							: {root_q[22:0], dv_ge};
					end
				end
			end
			S_CEN: begin
				idx_q <= '0;
				s1_q  <= '0;
				s2_q  <= '0;
			end
			S_CLD: begin
				a2_q <= {rd_m_q[16:1], 1'b0};
			end
			S_M1: begin
				neg_q <= d_w[17];
				dm_q  <= dm_w;
				p1_q  <= p1_w;
				idx_q <= idx_q + CNT_W'(1);
			end
			S_M2: begin
				s1_q <= neg_q ? s1_q - $signed({10'd0, p1_q}) : s1_q + $signed({10'd0, p1_q});
				p2_q <= p2_w;
			end
			S_AC: begin
				s2_q <= s2_q + {8'd0, p2_q};
				if (idx_q == n_q) begin
					ma_q   <= {26'd0, s2_q + {8'd0, p2_q}};
					mb_q   <= {18'd0, ftot_q};
					acc_q  <= '0;
					step_q <= 6'(MUL_STEPS - 1);
				end
			end
			S_MULF, S_MULS: begin
				if (step_q == 6'd0) begin
					if (state_q == S_MULF) begin
						prod_q <= mb_q[0] ? acc_q + ma_q : acc_q;
						ma_q   <= {42'd0, s1mag};
						mb_q   <= s1mag;
						acc_q  <= '0;
						step_q <= 6'(MUL_STEPS - 1);
					end else begin
						x_q      <= {q_w[81:0] - (mb_q[0] ? ma_q[81:0] : 82'd0), 14'd0};
						sq_rem_q <= '0;
						root_q   <= '0;
						step_q   <= 6'(SQRT_STEPS - 1);
					end
				end else begin
					acc_q  <= mb_q[0] ? acc_q + ma_q : acc_q;
					ma_q   <= {ma_q[82:0], 1'b0};
					mb_q   <= {1'b0, mb_q[41:1]};
					step_q <= step_q - 6'd1;
				end
			end
			S_SQRT: begin
				sq_rem_q <= sq_ge ? 50'(sq_sh - sq_trial) : sq_sh[49:0];
				root_q   <= {root_q[46:0], sq_ge};
				x_q      <= {x_q[93:0], 2'b00};
				if (step_q == 6'd0) begin
					dv_rem_q <= '0;
					step_q   <= 6'(DIV_STEPS - 1);
				end else begin
					step_q <= step_q - 6'd1;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

/* dv/tb_grouped_standard_deviation.sv */
// Self-checking testbench for the grouped standard deviation block.
// Drives class-row words, predicts each result word and checks it; depends on gsd_pkg.
`timescale 1ns / 100ps

module tb_grouped_standard_deviation;
	import gsd_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int TAIL_CYCLES    = 4 * MAX_CLASSES + 400;

	// Predictor of the block and queue of expected result words.
	class gsd_scoreboard;
		logic [16:0]      mid_buf [MAX_CLASSES];
		logic [15:0]      frq_buf [MAX_CLASSES];
		int unsigned      rows;
		bit               ovf;
		int               interval;
		logic [23:0]      total;
		out_word_t        pending [$];
		int unsigned      errors;
		int unsigned      tables;

		function void clear_table();
			rows = 0;
			ovf = 0;
			interval = 0;
			total = 0;
		endfunction

		// Integer square root of a 128-bit value, one bit at a time.
		function logic [63:0] isqrt(logic [127:0] x);
			logic [63:0] r;
			logic [63:0] c;
			r = 0;
			for (int k = 62; k >= 0; k--) begin
				c = r | (64'd1 << k);
				if (128'(c) * 128'(c) <= x)
					r = c;
			end
			return r;
		endfunction

		function void note_row(in_word_t w);
			out_word_t res;
			logic [24:0] sum;
			longint a2, d, s1;
			logic [63:0] s2, s1mag, root, sd;
			logic [127:0] q;
			if (rows < MAX_CLASSES) begin
				mid_buf[rows] = 17'(w.class_low) + 17'(w.class_high);
				frq_buf[rows] = w.frequency;
				if (rows == 1)
					interval = int'(w.class_high) - int'(w.class_low);
				rows++;
			end else begin
				ovf = 1;
			end
			sum = 25'(total) + 25'(w.frequency);
			if (sum > 25'hFFFFFF) begin
				total = 24'hFFFFFF;
				ovf = 1;
			end else begin
				total = sum[23:0];
			end
			if (!w.last_row)
				return;
			res.std_dev = 0;
			if (ovf)
				res.status = ST_OVERFLOW;
			else if (rows < 2)
				res.status = ST_FEW_ROWS;
			else if (interval == 0)
				res.status = ST_ZERO_INT;
			else if (total == 0)
				res.status = ST_ZERO_FRQ;
			else begin
				res.status = ST_OK;
				// The assumed mean is the truncated midpoint, kept doubled.
				a2 = longint'(mid_buf[rows / 2 - 1] >> 1) * 2;
				s1 = 0;
				s2 = 0;
				for (int i = 0; i < rows; i++) begin
					d = longint'(mid_buf[i]) - a2;
					s1 += longint'(frq_buf[i]) * d;
					s2 += 64'(frq_buf[i]) * 64'(d < 0 ? -d : d) * 64'(d < 0 ? -d : d);
				end
				s1mag = s1 < 0 ? 64'(-s1) : 64'(s1);
				q = 128'(total) * 128'(s2) - 128'(s1mag) * 128'(s1mag);
				root = isqrt(q << 14);
				sd = root / 64'(total);
				res.std_dev = sd > 64'hFFFFFF ? 24'hFFFFFF : sd[23:0];
			end
			pending.push_back(res);
			tables++;
			clear_table();
		endfunction

		function void check_result(out_word_t got);
			out_word_t exp_w;
			if (pending.size() == 0) begin
				$error("result word with nothing expected: std_dev=%0d status=%0d",
					got.std_dev, got.status);
				errors++;
				return;
			end
			exp_w = pending.pop_front();
			if (got.std_dev !== exp_w.std_dev) begin
				$error("std_dev expected %0d actual %0d", exp_w.std_dev, got.std_dev);
				errors++;
			end
			if (got.status !== exp_w.status) begin
				$error("status expected %0d actual %0d", exp_w.status, got.status);
				errors++;
			end
		endfunction
	endclass

	logic      clk;
	logic      arst_n;
	logic      start;
	in_word_t  row;
	logic      busy;
	out_word_t result;
	logic      done;

	gsd_scoreboard sb;
	int unsigned   idle_cycles;
	int unsigned   rows_sent;
	bit            quiet_phase;

	grouped_standard_deviation i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.row    (row),
		.busy   (busy),
		.result (result),
		.done   (done)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// Sampling at the rising edge: a word is taken when start is high and busy low,
	// and a result word is taken whenever done is high.
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				sb.note_row(row);
				rows_sent++;
			end
			if (done)
				sb.check_result(result);
			if ((start && !busy) || done)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Timeout: nothing accepted for %0d cycles", WATCHDOG_LIMIT);
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// Offers one word and holds it until the block takes it. Random gaps, each added
	// with a chance of 21 in 100, come before the word unless the quiet phase is on.
	// Start stays high afterwards, so the next word can follow without a gap.
	task automatic send_row(input logic [15:0] lo, input logic [15:0] hi,
			input logic [15:0] f, input logic last);
		while (!quiet_phase && $urandom_range(99) < 21) begin
			start <= 0;
			row <= in_word_t'($urandom);
			@(negedge clk);
		end
		start <= 1;
		row <= '{class_low: lo, class_high: hi, frequency: f, last_row: last};
		@(posedge clk);
		while (busy)
			@(posedge clk);
		@(negedge clk);
	endtask

	// A whole table of n rows with random content; the interval style decides
	// whether rows share one width, random widths, or reversed bounds.
	task automatic send_table(input int n, input int style);
		logic [15:0] lo, hi, f, w;
		w = 16'($urandom_range(1, 200));
		for (int i = 0; i < n; i++) begin
			case (style)
				0: begin
					lo = 16'(i * w + $urandom_range(0, 100));
					hi = lo + w;
				end
				1: begin
					lo = 16'($urandom);
					hi = 16'($urandom);
				end
				default: begin
					hi = 16'($urandom_range(0, 30000));
					lo = hi + w;
				end
			endcase
			case ($urandom_range(3))
				0: f = 16'($urandom);
				1: f = 16'($urandom_range(0, 3));
				default: f = 16'($urandom_range(0, 500));
			endcase
			send_row(lo, hi, f, i == n - 1);
		end
	endtask

	task automatic drain();
		int unsigned n;
		n = 0;
		start <= 0;
		while (sb.pending.size() != 0 && n < 200000) begin
			@(posedge clk);
			n++;
		end
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	initial begin
		sb = new();
		sb.clear_table();
		sb.errors = 0;
		sb.tables = 0;
		idle_cycles = 0;
		rows_sent = 0;
		quiet_phase = 0;
		start = 0;
		row = '0;
		arst_n = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Directed tables: a single row, zero interval, zero frequency, reversed
		// bounds, extreme bounds and frequencies, total overflow, buffer overflow.
		send_row(16'd10, 16'd20, 16'd5, 1);
		send_row(16'd10, 16'd10, 16'd5, 0);
		send_row(16'd10, 16'd10, 16'd5, 1);
		send_row(16'd0, 16'd10, 16'd0, 0);
		send_row(16'd10, 16'd20, 16'd0, 1);
		send_row(16'd20, 16'd30, 16'd3, 0);
		send_row(16'd30, 16'd20, 16'd7, 0);
		send_row(16'd40, 16'd50, 16'd1, 1);
		send_row(16'd0, 16'd0, 16'hFFFF, 0);
		send_row(16'hFFFF, 16'hFFFF, 16'hFFFF, 0);
		send_row(16'd0, 16'hFFFF, 16'd1, 1);
		for (int i = 0; i < 258; i++)
			send_row(16'd0, 16'hFFFF, 16'hFFFF, i == 257);
		for (int i = 0; i < 257; i++)
			send_row(16'(i), 16'(i + 1), 16'd1, i == 256);
		drain();

		// Random tables, mostly small so the arithmetic dominates; now and then
		// a full buffer and a stray row of noise.
		while (rows_sent < 1500) begin
			quiet_phase = (rows_sent > 1000 && rows_sent < 1300);
			case ($urandom_range(19))
				0: send_table($urandom_range(1, 2), $urandom_range(2));
				1: send_table($urandom_range(250, 257), 0);
				2: send_table($urandom_range(3, 6), 1);
				3: send_table($urandom_range(3, 6), 2);
				default: send_table($urandom_range(2, 12), 0);
			endcase
		end
		drain();

		$display("Sent %0d class rows forming %0d tables, with error, extreme and full tables.",
			rows_sent, sb.tables);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
